FILE: rtl/ccp_pkg.sv
// Shared types and constants for the class-file constant pool parser.
`timescale 1ns / 1ps

package ccp_pkg;

  // Default queue depths.
  localparam int MidDepthDefault = 4;
  localparam int OutDepthDefault = 4;

  // Constant pool tag codes.
  localparam logic [7:0] TAG_UTF8       = 8'd1;
  localparam logic [7:0] TAG_INTEGER    = 8'd3;
  localparam logic [7:0] TAG_FLOAT      = 8'd4;
  localparam logic [7:0] TAG_LONG       = 8'd5;
  localparam logic [7:0] TAG_DOUBLE     = 8'd6;
  localparam logic [7:0] TAG_CLASS      = 8'd7;
  localparam logic [7:0] TAG_STRING     = 8'd8;
  localparam logic [7:0] TAG_FIELDREF   = 8'd9;
  localparam logic [7:0] TAG_METHODREF  = 8'd10;
  localparam logic [7:0] TAG_IMETHODREF = 8'd11;
  localparam logic [7:0] TAG_NAMETYPE   = 8'd12;
  localparam logic [7:0] TAG_MHANDLE    = 8'd15;
  localparam logic [7:0] TAG_MTYPE      = 8'd16;
  localparam logic [7:0] TAG_INDY       = 8'd18;

  // Result record kinds.
  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_UTF8  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Payload layout class of a tag, decided by the front end.
  typedef enum logic [2:0] {
    TC_UNKNOWN,
    TC_UTF8,
    TC_REF1,
    TC_HANDLE,
    TC_INDY,
    TC_NUM32,
    TC_NUM64,
    TC_REF2
  } tag_class_t;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COUNT_LO,
    PH_TAG,
    PH_PAYLOAD,
    PH_STRING
  } phase_t;

  // One classified stream byte, passed from front to back.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    tag_class_t tclass;
    logic [3:0] plen;
  } mid_item_t;

  // One result record.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] number;
    logic [7:0]  tag;
    logic [15:0] first_ref;
    logic [15:0] second_ref;
    logic [63:0] raw_value;
    logic [7:0]  string_byte;
    logic        last;
  } result_t;

endpackage

FILE: rtl/class_constant_pool_parser.sv
// Class-file constant pool parser top level: front end, queues and back end.
// A byte's result reaches the output ports through the front-to-back queue and then
// the result queue, each of which registers it.
// Throughput: one byte per cycle, set by the back-end parser; a full result queue
// stalls the back end, and full rises once the front-to-back queue has filled.
// Reset (rst_n, synchronous, active low) empties both queues, idles the parser
// and sets ref_index_adjust to 1.
`timescale 1ns / 1ps

module class_constant_pool_parser #(
  parameter int MID_DEPTH = ccp_pkg::MidDepthDefault,
  parameter int OUT_DEPTH = ccp_pkg::OutDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input byte channel.
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_pool_start,
  // Result channel.
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_record_kind,
  output logic [15:0] out_entry_number,
  output logic [7:0]  out_entry_tag,
  output logic [15:0] out_first_ref,
  output logic [15:0] out_second_ref,
  output logic [63:0] out_raw_value,
  output logic [7:0]  out_string_byte,
  output logic        out_pool_last,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_ref_index_adjust
);

  localparam int MidW = $bits(ccp_pkg::mid_item_t);
  localparam int ResW = $bits(ccp_pkg::result_t);

  logic                 adjust_r, adjust_nxt;
  logic                 mid_push, mid_full, mid_empty, mid_pop;
  ccp_pkg::mid_item_t   mid_wr, mid_rd;
  logic [MidW-1:0]      mid_rd_bits;
  logic                 res_push, res_full;
  ccp_pkg::result_t     res_wr, res_rd;
  logic [ResW-1:0]      res_rd_bits;

  // Configuration register, always ready.
  assign cfg_ready  = 1'b1;
  assign adjust_nxt = (cfg_valid && cfg_ready) ? cfg_ref_index_adjust : adjust_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adjust_r <= 1'b1;
    end else begin
      adjust_r <= adjust_nxt;
    end
  end

  // Front end classifies incoming bytes.
  ccp_front u_front (
    .in_valid (push),
    .in_data  (in_byte),
    .in_start (in_pool_start),
    .q_full   (mid_full),
    .q_push   (mid_push),
    .q_item   (mid_wr)
  );

  assign full = mid_full;

  // Queue between front and back ends.
  ccp_queue #(
    .WIDTH (MidW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (mid_push),
    .wr_data (mid_wr),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_rd_bits),
    .empty   (mid_empty)
  );

  assign mid_rd = ccp_pkg::mid_item_t'(mid_rd_bits);

  // Back end parses and builds result records.
  ccp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ref_adjust (adjust_r),
    .q_empty    (mid_empty),
    .q_item     (mid_rd),
    .q_pop      (mid_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_wr)
  );

  // Result queue.
  ccp_queue #(
    .WIDTH (ResW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_rd_bits),
    .empty   (empty)
  );

  assign res_rd           = ccp_pkg::result_t'(res_rd_bits);
  assign out_record_kind  = res_rd.kind;
  assign out_entry_number = res_rd.number;
  assign out_entry_tag    = res_rd.tag;
  assign out_first_ref    = res_rd.first_ref;
  assign out_second_ref   = res_rd.second_ref;
  assign out_raw_value    = res_rd.raw_value;
  assign out_string_byte  = res_rd.string_byte;
  assign out_pool_last    = res_rd.last;

endmodule

FILE: rtl/ccp_queue.sv
// Small first-word-fall-through register queue.
`timescale 1ns / 1ps

module ccp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and occupancy update, pointers wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/ccp_front.sv
// Front end: accepts stream bytes and classifies each as a potential tag.
`timescale 1ns / 1ps

module ccp_front (
  input  logic                  in_valid,
  input  logic [7:0]            in_data,
  input  logic                  in_start,
  input  logic                  q_full,
  output logic                  q_push,
  output ccp_pkg::mid_item_t    q_item
);

  ccp_pkg::tag_class_t tclass;
  logic [3:0]          plen;

  // Decode the byte as a tag: payload layout and payload length.
  always_comb begin
    unique case (in_data)
      ccp_pkg::TAG_UTF8: begin
        tclass = ccp_pkg::TC_UTF8;
        plen   = 4'd2;
      end
      ccp_pkg::TAG_CLASS, ccp_pkg::TAG_STRING, ccp_pkg::TAG_MTYPE: begin
        tclass = ccp_pkg::TC_REF1;
        plen   = 4'd2;
      end
      ccp_pkg::TAG_MHANDLE: begin
        tclass = ccp_pkg::TC_HANDLE;
        plen   = 4'd3;
      end
      ccp_pkg::TAG_INDY: begin
        tclass = ccp_pkg::TC_INDY;
        plen   = 4'd4;
      end
      ccp_pkg::TAG_INTEGER, ccp_pkg::TAG_FLOAT: begin
        tclass = ccp_pkg::TC_NUM32;
        plen   = 4'd4;
      end
      ccp_pkg::TAG_LONG, ccp_pkg::TAG_DOUBLE: begin
        tclass = ccp_pkg::TC_NUM64;
        plen   = 4'd8;
      end
      ccp_pkg::TAG_FIELDREF, ccp_pkg::TAG_METHODREF, ccp_pkg::TAG_IMETHODREF,
      ccp_pkg::TAG_NAMETYPE: begin
        tclass = ccp_pkg::TC_REF2;
        plen   = 4'd4;
      end
      default: begin
        tclass = ccp_pkg::TC_UNKNOWN;
        plen   = 4'd0;
      end
    endcase
  end

  // A transaction is taken whenever the queue has room.
  assign q_push        = in_valid && !q_full;
  assign q_item.data   = in_data;
  assign q_item.start  = in_start;
  assign q_item.tclass = tclass;
  assign q_item.plen   = plen;

endmodule

FILE: rtl/ccp_back.sv
// Back end: constant pool parser state machine that builds result records.
`timescale 1ns / 1ps

module ccp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ref_adjust,
  input  logic                 q_empty,
  input  ccp_pkg::mid_item_t   q_item,
  output logic                 q_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output ccp_pkg::result_t     res
);

  ccp_pkg::phase_t     phase_r, phase_nxt;
  ccp_pkg::tag_class_t class_r, class_nxt;
  logic [15:0]         slots_r, slots_nxt;
  logic [15:0]         slot_cnt_r, slot_cnt_nxt;
  logic [7:0]          tag_r, tag_nxt;
  logic [15:0]         left_r, left_nxt;
  logic [63:0]         payload_r, payload_nxt;

  logic        fire;
  logic        emit;
  logic [63:0] shifted;
  logic [15:0] count_val;
  logic [15:0] left_dec;
  logic [15:0] slots_after;
  logic [1:0]  consume;
  logic [15:0] num_adj;

  assign fire     = !q_empty && !res_full;
  assign q_pop    = fire;
  assign res_push = fire && emit;

  assign shifted   = {payload_r[55:0], q_item.data};
  assign count_val = {payload_r[7:0], q_item.data};
  assign left_dec  = left_r - 16'd1;
  assign consume   = (class_r == ccp_pkg::TC_NUM64) ? 2'd2 : 2'd1;
  assign slots_after = (slots_r > {14'd0, consume}) ? slots_r - {14'd0, consume} : 16'd0;
  assign num_adj   = slot_cnt_r - {15'd0, ref_adjust};

  // Next state and result record for the byte at the head of the queue.
  always_comb begin
    phase_nxt    = phase_r;
    class_nxt    = class_r;
    slots_nxt    = slots_r;
    slot_cnt_nxt = slot_cnt_r;
    tag_nxt      = tag_r;
    left_nxt     = left_r;
    payload_nxt  = payload_r;
    emit         = 1'b0;
    res          = '0;
    if (fire) begin
      if (q_item.start) begin
        // A start mark restarts parsing with the count high byte.
        payload_nxt  = {56'd0, q_item.data};
        phase_nxt    = ccp_pkg::PH_COUNT_LO;
        slots_nxt    = '0;
        slot_cnt_nxt = '0;
        tag_nxt      = '0;
        left_nxt     = '0;
      end else begin
        unique case (phase_r)
          ccp_pkg::PH_IDLE: begin
          end
          ccp_pkg::PH_COUNT_LO: begin
            payload_nxt  = '0;
            slot_cnt_nxt = 16'd1;
            slots_nxt    = (count_val != 16'd0) ? count_val - 16'd1 : 16'd0;
            if (count_val <= 16'd1) begin
              phase_nxt = ccp_pkg::PH_IDLE;
              emit      = 1'b1;
              res.kind  = ccp_pkg::KIND_EMPTY;
              res.last  = 1'b1;
            end else begin
              phase_nxt = ccp_pkg::PH_TAG;
            end
          end
          ccp_pkg::PH_TAG: begin
            tag_nxt   = q_item.data;
            class_nxt = q_item.tclass;
            if (q_item.tclass == ccp_pkg::TC_UNKNOWN) begin
              phase_nxt  = ccp_pkg::PH_IDLE;
              slots_nxt  = '0;
              emit       = 1'b1;
              res.kind   = ccp_pkg::KIND_ERROR;
              res.number = num_adj;
              res.tag    = q_item.data;
              res.last   = 1'b1;
            end else begin
              left_nxt    = {12'd0, q_item.plen};
              payload_nxt = '0;
              phase_nxt   = ccp_pkg::PH_PAYLOAD;
            end
          end
          ccp_pkg::PH_PAYLOAD: begin
            payload_nxt = shifted;
            left_nxt    = left_dec;
            if (left_dec == 16'd0) begin
              // Payload complete: decode fields by layout.
              emit       = 1'b1;
              res.kind   = ccp_pkg::KIND_ENTRY;
              res.number = num_adj;
              res.tag    = tag_r;
              unique case (class_r)
                ccp_pkg::TC_UTF8: res.first_ref = shifted[15:0];
                ccp_pkg::TC_REF1:
                  res.first_ref = shifted[15:0] - {15'd0, ref_adjust};
                ccp_pkg::TC_HANDLE: begin
                  res.first_ref  = {8'd0, shifted[23:16]};
                  res.second_ref = shifted[15:0] - {15'd0, ref_adjust};
                end
                ccp_pkg::TC_INDY: begin
                  res.first_ref  = shifted[31:16];
                  res.second_ref = shifted[15:0] - {15'd0, ref_adjust};
                end
                ccp_pkg::TC_NUM32: res.raw_value = {32'd0, shifted[31:0]};
                ccp_pkg::TC_NUM64: res.raw_value = shifted;
                default: begin
                  res.first_ref  = shifted[31:16] - {15'd0, ref_adjust};
                  res.second_ref = shifted[15:0] - {15'd0, ref_adjust};
                end
              endcase
              slots_nxt = slots_after;
              if (class_r == ccp_pkg::TC_UTF8 && shifted[15:0] != 16'd0) begin
                left_nxt  = shifted[15:0];
                phase_nxt = ccp_pkg::PH_STRING;
              end else begin
                res.last     = (slots_after == 16'd0);
                slot_cnt_nxt = slot_cnt_r + {14'd0, consume};
                phase_nxt    = (slots_after == 16'd0) ? ccp_pkg::PH_IDLE : ccp_pkg::PH_TAG;
              end
            end
          end
          ccp_pkg::PH_STRING: begin
            // One result per string data byte.
            left_nxt        = left_dec;
            emit            = 1'b1;
            res.kind        = ccp_pkg::KIND_UTF8;
            res.number      = num_adj;
            res.tag         = tag_r;
            res.string_byte = q_item.data;
            res.last        = (left_dec == 16'd0) && (slots_r == 16'd0);
            if (left_dec == 16'd0) begin
              slot_cnt_nxt = slot_cnt_r + {14'd0, consume};
              phase_nxt    = (slots_r == 16'd0) ? ccp_pkg::PH_IDLE : ccp_pkg::PH_TAG;
            end
          end
          default: begin
            phase_nxt = ccp_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= ccp_pkg::PH_IDLE;
      class_r    <= ccp_pkg::TC_UNKNOWN;
      slots_r    <= '0;
      slot_cnt_r <= '0;
      tag_r      <= '0;
      left_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      class_r    <= class_nxt;
      slots_r    <= slots_nxt;
      slot_cnt_r <= slot_cnt_nxt;
      tag_r      <= tag_nxt;
      left_r     <= left_nxt;
    end
  end

  // Payload shift register.
  always_ff @(posedge clk) begin
    payload_r <= payload_nxt;
  end

  // The payload counter stays within one fixed-size payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ccp_pkg::PH_PAYLOAD) |-> (left_r != 16'd0 && left_r <= 16'd8))
    else $error("payload byte counter out of range");

  // A string in progress always has data bytes left.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ccp_pkg::PH_STRING) |-> (left_r != 16'd0))
    else $error("string phase with no bytes left");

  // Waiting for a tag means at least one slot is still open.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ccp_pkg::PH_TAG) |-> (slots_r != 16'd0))
    else $error("tag phase with no slots remaining");

  // The final result of a pool leaves the parser idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.last) |=> (phase_r == ccp_pkg::PH_IDLE))
    else $error("parser not idle after final result");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the class-file constant pool parser.
`timescale 1ns / 1ps

module testbench;

  // Cycles to let the queues settle once every expected record has arrived.
  localparam int DRAIN_SETTLE = 16;
  // Cycles without any transaction before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Length of the long receiver hold-off.
  localparam int HOLD_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = 8'd0;
  logic        in_pool_start = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_record_kind;
  logic [15:0] out_entry_number;
  logic [7:0]  out_entry_tag;
  logic [15:0] out_first_ref;
  logic [15:0] out_second_ref;
  logic [63:0] out_raw_value;
  logic [7:0]  out_string_byte;
  logic        out_pool_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_ref_index_adjust = 1'b0;

  // Parser state as the testbench expects it, starting at its reset values.
  ccp_pkg::phase_t parse_state = ccp_pkg::PH_IDLE;
  logic [15:0]     slots_left = 16'd0;
  logic [15:0]     slot_no = 16'd0;
  logic [7:0]      cur_tag = 8'd0;
  logic [15:0]     bytes_due = 16'd0;
  logic [63:0]     shift_acc = 64'd0;
  logic            index_adjust = 1'b1;

  ccp_pkg::result_t pending_records[$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      bytes_sent = 0;
  bit      steady_flow = 1'b0;
  bit      rx_hold_req = 1'b0;

  class_constant_pool_parser dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_byte              (in_byte),
    .in_pool_start        (in_pool_start),
    .empty                (empty),
    .pop                  (pop),
    .out_record_kind      (out_record_kind),
    .out_entry_number     (out_entry_number),
    .out_entry_tag        (out_entry_tag),
    .out_first_ref        (out_first_ref),
    .out_second_ref       (out_second_ref),
    .out_raw_value        (out_raw_value),
    .out_string_byte      (out_string_byte),
    .out_pool_last        (out_pool_last),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_ref_index_adjust (cfg_ref_index_adjust)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Fixed payload length of each tag; zero marks an unknown tag.
  function automatic int tag_payload_bytes(input logic [7:0] t);
    case (t)
      ccp_pkg::TAG_UTF8, ccp_pkg::TAG_CLASS, ccp_pkg::TAG_STRING,
      ccp_pkg::TAG_MTYPE: return 2;
      ccp_pkg::TAG_MHANDLE: return 3;
      ccp_pkg::TAG_INTEGER, ccp_pkg::TAG_FLOAT, ccp_pkg::TAG_FIELDREF,
      ccp_pkg::TAG_METHODREF, ccp_pkg::TAG_IMETHODREF, ccp_pkg::TAG_NAMETYPE,
      ccp_pkg::TAG_INDY: return 4;
      ccp_pkg::TAG_LONG, ccp_pkg::TAG_DOUBLE: return 8;
      default: return 0;
    endcase
  endfunction

  function automatic bit is_wide(input logic [7:0] t);
    return (t == ccp_pkg::TAG_LONG) || (t == ccp_pkg::TAG_DOUBLE);
  endfunction

  // Reference indices and slot numbers, optionally made zero based.
  function automatic logic [15:0] slot_ref(input logic [15:0] v);
    return v - {15'd0, index_adjust};
  endfunction

  // Step past the finished entry and decide whether the pool goes on.
  function automatic void close_entry();
    slot_no = slot_no + (is_wide(cur_tag) ? 16'd2 : 16'd1);
    parse_state = (slots_left == 16'd0) ? ccp_pkg::PH_IDLE : ccp_pkg::PH_TAG;
  endfunction

  // Advance the expected parser state by one byte; returns 1 when a record results.
  function automatic bit parse_pool_byte(input logic [7:0] b, input logic st,
                                         output ccp_pkg::result_t r);
    logic [15:0] count;
    logic [15:0] consume;
    int          len;
    r = '0;
    // A start mark always opens a new pool, dropping whatever was in progress.
    if (st) begin
      shift_acc = {56'd0, b};
      parse_state = ccp_pkg::PH_COUNT_LO;
      slots_left = 16'd0;
      slot_no = 16'd0;
      cur_tag = 8'd0;
      bytes_due = 16'd0;
      return 1'b0;
    end
    case (parse_state)
      ccp_pkg::PH_COUNT_LO: begin
        count = {shift_acc[7:0], b};
        shift_acc = 64'd0;
        slot_no = 16'd1;
        slots_left = (count != 16'd0) ? count - 16'd1 : 16'd0;
        if (slots_left == 16'd0) begin
          parse_state = ccp_pkg::PH_IDLE;
          r.kind = ccp_pkg::KIND_EMPTY;
          r.last = 1'b1;
          return 1'b1;
        end
        parse_state = ccp_pkg::PH_TAG;
        return 1'b0;
      end
      ccp_pkg::PH_TAG: begin
        len = tag_payload_bytes(b);
        cur_tag = b;
        if (len == 0) begin
          parse_state = ccp_pkg::PH_IDLE;
          slots_left = 16'd0;
          r.kind = ccp_pkg::KIND_ERROR;
          r.number = slot_ref(slot_no);
          r.tag = b;
          r.last = 1'b1;
          return 1'b1;
        end
        bytes_due = len[15:0];
        shift_acc = 64'd0;
        parse_state = ccp_pkg::PH_PAYLOAD;
        return 1'b0;
      end
      ccp_pkg::PH_PAYLOAD: begin
        shift_acc = {shift_acc[55:0], b};
        bytes_due = bytes_due - 16'd1;
        if (bytes_due != 16'd0) return 1'b0;
        // Payload complete: split it according to the tag layout.
        case (cur_tag)
          ccp_pkg::TAG_UTF8: r.first_ref = shift_acc[15:0];
          ccp_pkg::TAG_CLASS, ccp_pkg::TAG_STRING, ccp_pkg::TAG_MTYPE:
            r.first_ref = slot_ref(shift_acc[15:0]);
          ccp_pkg::TAG_MHANDLE: begin
            r.first_ref = {8'd0, shift_acc[23:16]};
            r.second_ref = slot_ref(shift_acc[15:0]);
          end
          ccp_pkg::TAG_INDY: begin
            r.first_ref = shift_acc[31:16];
            r.second_ref = slot_ref(shift_acc[15:0]);
          end
          ccp_pkg::TAG_INTEGER, ccp_pkg::TAG_FLOAT:
            r.raw_value = {32'd0, shift_acc[31:0]};
          ccp_pkg::TAG_LONG, ccp_pkg::TAG_DOUBLE: r.raw_value = shift_acc;
          default: begin
            r.first_ref = slot_ref(shift_acc[31:16]);
            r.second_ref = slot_ref(shift_acc[15:0]);
          end
        endcase
        consume = is_wide(cur_tag) ? 16'd2 : 16'd1;
        slots_left = (slots_left > consume) ? slots_left - consume : 16'd0;
        r.kind = ccp_pkg::KIND_ENTRY;
        r.number = slot_ref(slot_no);
        r.tag = cur_tag;
        if (cur_tag == ccp_pkg::TAG_UTF8 && r.first_ref != 16'd0) begin
          bytes_due = r.first_ref;
          parse_state = ccp_pkg::PH_STRING;
          r.last = 1'b0;
        end else begin
          r.last = (slots_left == 16'd0);
          close_entry();
        end
        return 1'b1;
      end
      ccp_pkg::PH_STRING: begin
        r.kind = ccp_pkg::KIND_UTF8;
        r.number = slot_ref(slot_no);
        r.tag = cur_tag;
        r.string_byte = b;
        bytes_due = bytes_due - 16'd1;
        r.last = (bytes_due == 16'd0) && (slots_left == 16'd0);
        if (bytes_due == 16'd0) close_entry();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // Observe every transaction at the rising edge: configuration, results and input bytes.
  always @(posedge clk) begin : observe
    ccp_pkg::result_t want;
    ccp_pkg::result_t fresh;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) index_adjust = cfg_ref_index_adjust;
      if (!empty && pop) begin
        if (pending_records.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected record, expected none, actual kind %0d number %0h",
                   $time, out_record_kind, out_entry_number);
        end else begin
          want = pending_records.pop_front();
          check_field("record_kind", 64'(want.kind), 64'(out_record_kind));
          check_field("entry_number", 64'(want.number), 64'(out_entry_number));
          check_field("entry_tag", 64'(want.tag), 64'(out_entry_tag));
          check_field("first_ref", 64'(want.first_ref), 64'(out_first_ref));
          check_field("second_ref", 64'(want.second_ref), 64'(out_second_ref));
          check_field("raw_value", want.raw_value, out_raw_value);
          check_field("string_byte", 64'(want.string_byte), 64'(out_string_byte));
          check_field("pool_last", 64'(want.last), 64'(out_pool_last));
        end
      end
      if (push && !full) begin
        if (parse_pool_byte(in_byte, in_pool_start, fresh)) pending_records.push_back(fresh);
      end
      // Hang detection: count cycles in which no transaction of any kind happens.
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  // Result side: random pop stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        pop <= steady_flow || ($urandom_range(99) >= 7);
      end
    end
  end

  // Offer one byte and hold it until the parser takes it; ends on a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic st);
    if (!steady_flow && $urandom_range(99) < 7) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    in_pool_start <= st;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Stop offering bytes until every expected record has come out.
  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk);
    while (pending_records.size() != 0) @(negedge clk);
  endtask

  task automatic write_ref_adjust(input logic v);
    wait_drained();
    repeat (DRAIN_SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_ref_index_adjust <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Payload bytes lean toward all zeros and all ones to reach reference wrap.
  function automatic logic [7:0] pick_payload_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_tag();
    case ($urandom_range(13))
      0: return ccp_pkg::TAG_UTF8;
      1: return ccp_pkg::TAG_INTEGER;
      2: return ccp_pkg::TAG_FLOAT;
      3: return ccp_pkg::TAG_LONG;
      4: return ccp_pkg::TAG_DOUBLE;
      5: return ccp_pkg::TAG_CLASS;
      6: return ccp_pkg::TAG_STRING;
      7: return ccp_pkg::TAG_FIELDREF;
      8: return ccp_pkg::TAG_METHODREF;
      9: return ccp_pkg::TAG_IMETHODREF;
      10: return ccp_pkg::TAG_NAMETYPE;
      11: return ccp_pkg::TAG_MHANDLE;
      12: return ccp_pkg::TAG_MTYPE;
      default: return ccp_pkg::TAG_INDY;
    endcase
  endfunction

  // One well-formed entry with random content; strings are mostly short.
  task automatic send_entry(input logic [7:0] t);
    int str_len;
    send_byte(t, 1'b0);
    if (t == ccp_pkg::TAG_UTF8) begin
      str_len = ($urandom_range(9) == 0) ? int'($urandom_range(40))
                                         : int'($urandom_range(6));
      send_byte(8'd0, 1'b0);
      send_byte(str_len[7:0], 1'b0);
      repeat (str_len) send_byte(8'($urandom_range(255)), 1'b0);
    end else begin
      repeat (tag_payload_bytes(t)) send_byte(pick_payload_byte(), 1'b0);
    end
  endtask

  // A pool with the given count; it may be cut short, hit an unknown tag or pause mid-way.
  task automatic send_pool(input logic [15:0] count, input int max_entries,
                           input bit may_break);
    int         left;
    int         entries;
    logic [7:0] t;
    send_byte(count[15:8], 1'b1);
    send_byte(count[7:0], 1'b0);
    left = (count == 16'd0) ? 0 : int'(count) - 1;
    entries = 0;
    while (left > 0 && entries < max_entries) begin
      if (may_break && $urandom_range(99) < 3) begin
        // Abandon the pool part way into an entry; the next start mark restarts.
        t = pick_tag();
        send_byte(t, 1'b0);
        repeat ($urandom_range(tag_payload_bytes(t) - 1)) send_byte(pick_payload_byte(), 1'b0);
        return;
      end
      if (may_break && $urandom_range(99) < 2) begin
        do t = 8'($urandom_range(255)); while (tag_payload_bytes(t) != 0);
        send_byte(t, 1'b0);
        return;
      end
      t = pick_tag();
      send_entry(t);
      left = left - (is_wide(t) ? 2 : 1);
      entries++;
      if ($urandom_range(99) < 3) wait_drained();
    end
  endtask

  task automatic test_empty_pools();
    send_pool(16'd0, 0, 1'b0);
    send_pool(16'd1, 0, 1'b0);
  endtask

  // A class reference of zero wraps when indices are made zero based.
  task automatic test_zero_ref_wrap();
    send_byte(8'd0, 1'b1);
    send_byte(8'd2, 1'b0);
    send_byte(ccp_pkg::TAG_CLASS, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // A long value in the only slot left still closes the pool.
  task automatic test_wide_entry_last_slot();
    send_byte(8'd0, 1'b1);
    send_byte(8'd2, 1'b0);
    send_byte(ccp_pkg::TAG_LONG, 1'b0);
    repeat (8) send_byte(8'hFF, 1'b0);
  endtask

  // Unknown tags at both ends of the byte range; bytes after an error are ignored.
  task automatic test_unknown_tag();
    send_byte(8'd0, 1'b1);
    send_byte(8'd3, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'd0, 1'b1);
    send_byte(8'd2, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // Receiver stops for a long stretch while a large pool keeps arriving.
  task automatic test_output_backpressure();
    push <= 1'b0;
    @(posedge clk);
    rx_hold_req = 1'b1;
    @(negedge clk);
    send_pool(16'd16, 65535, 1'b0);
    wait_drained();
  endtask

  // Mostly well-formed pools, with empty pools, broken pools and stray bytes mixed in.
  task automatic test_random_traffic(input int goal, input bit calm);
    int stop_at;
    int pick;
    stop_at = bytes_sent + goal;
    steady_flow = calm;
    while (bytes_sent < stop_at) begin
      pick = int'($urandom_range(99));
      if (pick < 6)
        send_pool(16'($urandom_range(1)), 0, 1'b0);
      else if (pick < 16)
        send_pool(16'($urandom_range(65535)), int'($urandom_range(1, 5)), 1'b1);
      else
        send_pool(16'($urandom_range(2, 14)), 65535, pick < 35);
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
    end
    steady_flow = 1'b0;
  endtask

  // Test sequence.
  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_pools();
    test_zero_ref_wrap();
    test_wide_entry_last_slot();
    test_unknown_tag();
    test_random_traffic(160, 1'b0);
    write_ref_adjust(1'b0);
    test_zero_ref_wrap();
    test_random_traffic(160, 1'b1);
    write_ref_adjust(1'b1);
    test_output_backpressure();
    test_random_traffic(150, 1'b0);
    write_ref_adjust(1'b0);
    test_random_traffic(100, 1'b0);
    wait_drained();
    repeat (DRAIN_SETTLE) @(negedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ccp_pkg.sv
rtl/ccp_queue.sv
rtl/ccp_front.sv
rtl/ccp_back.sv
rtl/class_constant_pool_parser.sv
tb/sv/testbench.sv
